@@ design/vlan_tag_frame_counter_macros.svh @@
// Assertion macros for the VLAN tag frame counter checker.
// Used by vtfc_checker.sv; needs clk and rst in the including scope.
`ifndef VLAN_TAG_FRAME_COUNTER_MACROS_SVH
`define VLAN_TAG_FRAME_COUNTER_MACROS_SVH

// same-cycle implication
`define VTFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/vtfc_pkg.sv @@
// Shared types, constants and functions of the VLAN tag frame counter.
// No dependencies; used by every module of the block.
`default_nettype none

package vtfc_pkg;

  localparam int VLAN_ENTRIES = 4096;
  localparam int COUNT_BITS   = 32;
  localparam int IDX_BITS     = $clog2(VLAN_ENTRIES);
  localparam int VID_BITS     = 12;
  localparam int REPORT_BITS  = 32;

  localparam logic [15:0] HDR_BYTES      = 16'd14;
  localparam logic [15:0] TAG_TYPE_RESET = 16'h8100;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [REPORT_BITS-1:0] report_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [VID_BITS-1:0]    vid_t;

  typedef enum logic [1:0] {
    OUT_SHORT    = 2'd0,
    OUT_TAGGED   = 2'd1,
    OUT_UNTAGGED = 2'd2,
    OUT_READ     = 2'd3
  } outcome_t;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [15:0] tag_control;
    vid_t        query_vlan;
  } req_t;

  typedef struct packed {
    outcome_t outcome;
    vid_t     vlan_id;
    report_t  vlan_count;
    report_t  total_frames;
    report_t  tagged_frames;
    report_t  untagged_frames;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clr_we;
    logic rd;
    logic upd;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } stat_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic report_t report(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[REPORT_BITS-1:0];
  endfunction

  function automatic logic in_store(vid_t v);
    return 32'(v) < 32'(VLAN_ENTRIES);
  endfunction

endpackage

`default_nettype wire

@@ design/vtfc_ctrl.sv @@
// Controller of the VLAN tag frame counter: clear pass, read, update.
// Depends on vtfc_pkg.
`default_nettype none

module vtfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire vtfc_pkg::stat_t stat,
  output vtfc_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_UPD
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      busy  <= 1'b1;
    end else begin
      unique case (state)
        S_CLR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_RD;
            busy  <= 1'b1;
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_CLR;
          busy  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture = (state == S_IDLE) && start;
    cmd.clr_we  = (state == S_CLR);
    cmd.rd      = (state == S_RD);
    cmd.upd     = (state == S_UPD);
  end

endmodule

`default_nettype wire

@@ design/vtfc_datapath.sv @@
// Datapath of the VLAN tag frame counter: count store, totals, result register.
// Depends on vtfc_pkg; driven by vtfc_ctrl commands.
`default_nettype none

module vtfc_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire vtfc_pkg::req_t req,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  wire vtfc_pkg::cmd_t cmd,
  output vtfc_pkg::stat_t    stat,
  output vtfc_pkg::rsp_t     result,
  output logic               done
);

  vtfc_pkg::count_t vlan_mem [vtfc_pkg::VLAN_ENTRIES];

  logic [15:0]       tag_ethertype;
  vtfc_pkg::req_t    req_q;
  vtfc_pkg::idx_t    clr_idx;
  vtfc_pkg::count_t  rd_data;
  vtfc_pkg::count_t  frames_total;
  vtfc_pkg::count_t  frames_tagged;
  vtfc_pkg::count_t  frames_untagged;

  vtfc_pkg::vid_t    sel_vid;
  vtfc_pkg::idx_t    sel_idx;
  logic              sel_in_store;
  logic              is_read;
  logic              is_short;
  logic              is_tagged;
  logic              mem_we;
  vtfc_pkg::count_t  vlan_next;
  vtfc_pkg::count_t  total_next;
  vtfc_pkg::count_t  tagged_next;
  vtfc_pkg::count_t  untagged_next;
  vtfc_pkg::rsp_t    result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_ethertype <= vtfc_pkg::TAG_TYPE_RESET;
    end else if (cfg_we) begin
      tag_ethertype <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_we) begin
      clr_idx <= clr_idx + vtfc_pkg::IDX_BITS'(1);
    end
  end

  assign stat.clr_last = (clr_idx == vtfc_pkg::IDX_BITS'(vtfc_pkg::VLAN_ENTRIES - 1));

  // read replies use the query id, frames the id from the tag word
  assign sel_vid      = (req_q.req_type == vtfc_pkg::REQ_READ) ? req_q.query_vlan
                                                               : req_q.tag_control[11:0];
  assign sel_idx      = sel_vid[vtfc_pkg::IDX_BITS-1:0];
  assign sel_in_store = vtfc_pkg::in_store(sel_vid);

  assign is_read   = (req_q.req_type == vtfc_pkg::REQ_READ);
  assign is_short  = (req_q.frame_length < vtfc_pkg::HDR_BYTES);
  assign is_tagged = !is_read && !is_short && (req_q.ether_type == tag_ethertype);
  assign mem_we    = cmd.upd && is_tagged && sel_in_store;
  assign vlan_next = vtfc_pkg::sat_inc(rd_data);

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      vlan_mem[clr_idx] <= '0;
    end else if (mem_we) begin
      vlan_mem[sel_idx] <= vlan_next;
    end
    if (cmd.rd) begin
      rd_data <= vlan_mem[sel_idx];
    end
  end

  always_comb begin
    total_next    = frames_total;
    tagged_next   = frames_tagged;
    untagged_next = frames_untagged;
    result_next   = '0;
    if (is_read) begin
      result_next.outcome    = vtfc_pkg::OUT_READ;
      result_next.vlan_id    = sel_vid;
      result_next.vlan_count = sel_in_store ? vtfc_pkg::report(rd_data) : '0;
    end else begin
      total_next = vtfc_pkg::sat_inc(frames_total);
      if (is_short) begin
        result_next.outcome = vtfc_pkg::OUT_SHORT;
      end else if (is_tagged) begin
        result_next.outcome    = vtfc_pkg::OUT_TAGGED;
        result_next.vlan_id    = sel_vid;
        result_next.vlan_count = sel_in_store ? vtfc_pkg::report(vlan_next) : '0;
        tagged_next            = vtfc_pkg::sat_inc(frames_tagged);
      end else begin
        result_next.outcome = vtfc_pkg::OUT_UNTAGGED;
        untagged_next       = vtfc_pkg::sat_inc(frames_untagged);
      end
    end
    result_next.total_frames    = vtfc_pkg::report(total_next);
    result_next.tagged_frames   = vtfc_pkg::report(tagged_next);
    result_next.untagged_frames = vtfc_pkg::report(untagged_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_total    <= '0;
      frames_tagged   <= '0;
      frames_untagged <= '0;
      done            <= 1'b0;
    end else begin
      done <= cmd.upd;
      if (cmd.upd) begin
        frames_total    <= total_next;
        frames_tagged   <= tagged_next;
        frames_untagged <= untagged_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ design/vlan_tag_frame_counter.sv @@
// Top level of the VLAN tag frame counter: controller plus datapath.
// Depends on vtfc_pkg, vtfc_ctrl, vtfc_datapath.
//
//   channel   signals                   direction  handshake
//   request   start, busy, req          in         taken when start && !busy
//   result    done, result              out        one-cycle strobe, no stall
//   config    cfg_we, cfg_wdata         in         written when cfg_we
//
// Each transaction runs through capture, count store read, and update with
// write-back; done pulses in the cycle after the update, while busy is already
// low, so the next start can be taken then. After rst, busy stays high while
// the store is cleared one entry a cycle; config writes are taken throughout.
`default_nettype none

module vlan_tag_frame_counter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire vtfc_pkg::req_t req,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  output logic               done,
  output vtfc_pkg::rsp_t     result
);

  vtfc_pkg::cmd_t  cmd;
  vtfc_pkg::stat_t stat;

  vtfc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  vtfc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule

`default_nettype wire

@@ design/vtfc_checker.sv @@
// Port-level checker for the VLAN tag frame counter, bound to the top level.
// Depends on vtfc_pkg and vlan_tag_frame_counter_macros.svh.
`default_nettype none

`include "vlan_tag_frame_counter_macros.svh"

module vtfc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire vtfc_pkg::rsp_t result
);

  `VTFC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `VTFC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `VTFC_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `VTFC_ASSERT_NOW(a_done_latency, done, $past(start && !busy, 3),
                   "result without a transaction three cycles earlier")
  `VTFC_ASSERT_NOW(a_result_known, done, !$isunknown(result), "result has unknown bits")

endmodule

bind vlan_tag_frame_counter vtfc_checker u_vtfc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
